// ===== rtl/core/swm_pkg.sv =====
package swm_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int SAMPLE_W   = 32;
    localparam int AGE_W      = $clog2(WINDOW_MAX);
    localparam int IDX_W      = AGE_W;
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
    localparam int OUT_W      = SAMPLE_W + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr above the byte offset.
    localparam logic REG_WINDOW_LEN = 1'b0;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             clear;
        sample_t          sample;
        logic [AGE_W-1:0] del_age;
    } cell_ctl_t;

    // What a cell shows its left neighbor: its stored entry and its compare result.
    typedef struct packed {
        logic             vld;
        sample_t          val;
        logic [AGE_W-1:0] age;
        logic             le;
    } cell_raw_t;

    // What a cell hands its right neighbor: its entry after the removal step.
    typedef struct packed {
        logic             dle;
        logic             ble;
        logic             vld;
        sample_t          val;
        logic [AGE_W-1:0] age;
    } cell_fwd_t;

endpackage

// ===== rtl/core/sliding_window_median.sv =====
// Sliding-window median filter. Signed samples enter on the s_ channel and are kept in a
// row of cells in sorted order, each tagged with its age; on a full window a transaction
// removes the oldest entry and inserts the new sample in the same cycle, so the filter
// takes one sample per clock in steady operation while m_ready keeps up. The result, twice
// the median of the last window_len samples, is registered in the output register once
// the cell row holds its sample and leaves on the m_ channel; nothing is sent until the
// window is full. A sample with s_start_req set empties the window first. After window_len
// is made shorter, the next sample waits while the row drops its oldest entries beyond it.
// A window_len of 0 acts as 1, values above 32 act as 32. No clearing pass follows reset.
module sliding_window_median (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [swm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_start_req,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [swm_pkg::OUT_W-1:0]    m_median_x2
);
    import swm_pkg::*;

    logic [LEN_W-1:0] win_len_reg;
    logic [LEN_W-1:0] win_len_next;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic             pend_reg;
    logic             pend_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic signed [OUT_W-1:0] median_reg;
    logic signed [OUT_W-1:0] median_next;

    logic [LEN_W-1:0] len_eff;
    logic             cfg_wr;
    logic             adv;
    logic             slot_ok;
    logic             over;
    logic             acc;
    logic             drop;
    logic [LEN_W-1:0] fill_dec;
    cell_ctl_t        ctl;

    cell_fwd_t        fwd_link [0:WINDOW_MAX];
    cell_raw_t        raw_link [0:WINDOW_MAX];
    logic [WINDOW_MAX-1:0] vld_vec;

    logic [IDX_W-1:0] idx_hi;
    logic [IDX_W-1:0] idx_lo;
    sample_t          tap_hi;
    sample_t          tap_lo;

    // Configuration port
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_WINDOW_LEN);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_WINDOW_LEN)
                    ? {{(APB_DATA_W-LEN_W){1'b0}}, win_len_reg} : '0;
    assign win_len_next = cfg_wr ? pwdata[LEN_W-1:0] : win_len_reg;

    always_comb begin
        if (win_len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (win_len_reg > LEN_W'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = win_len_reg;
        end
    end

    // Flow control
    assign adv     = !m_valid_reg || m_ready;
    assign slot_ok = !pend_reg || adv;
    assign over    = fill_reg > len_eff;
    assign s_ready = slot_ok && (s_start_req || !over);
    assign acc     = s_valid && s_ready;
    // After a window shrink, a waiting transaction trims the row one entry a cycle while slot_ok holds.
    assign drop    = s_valid && slot_ok && !s_start_req && over;
    assign fill_dec = fill_reg - LEN_W'(1);

    assign ctl.ins     = acc;
    assign ctl.clear   = acc && s_start_req;
    assign ctl.del     = drop || (acc && !s_start_req && (fill_reg == len_eff));
    assign ctl.sample  = s_sample;
    assign ctl.del_age = fill_dec[AGE_W-1:0];

    always_comb begin
        fill_next = fill_reg;
        if (acc) begin
            if (s_start_req) begin
                fill_next = LEN_W'(1);
            end else if (fill_reg != len_eff) begin
                fill_next = fill_reg + LEN_W'(1);
            end
        end else if (drop) begin
            fill_next = fill_dec;
        end
    end

    always_comb begin
        if (acc) begin
            pend_next = (fill_next == len_eff);
        end else if (adv) begin
            pend_next = 1'b0;
        end else begin
            pend_next = pend_reg;
        end
    end

    assign m_valid_next = adv ? pend_reg : m_valid_reg;

    // Cell row
    assign fwd_link[0] = '{dle: 1'b0, ble: 1'b1, vld: 1'b0, val: '0, age: '0};
    assign raw_link[WINDOW_MAX] = '{vld: 1'b0, val: '0, age: '0, le: 1'b0};

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        swm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .left_in  (fwd_link[i]),
            .right_in (raw_link[i+1]),
            .raw_out  (raw_link[i]),
            .fwd_out  (fwd_link[i+1])
        );
        assign vld_vec[i] = raw_link[i].vld;
    end

    // Median taps: the middle one or two sorted positions for the current length.
    assign idx_hi = len_eff[LEN_W-1:1];
    assign idx_lo = len_eff[0] ? idx_hi : (idx_hi - IDX_W'(1));

    always_comb begin
        tap_hi = '0;
        tap_lo = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (IDX_W'(i) == idx_hi) begin
                tap_hi = tap_hi | raw_link[i].val;
            end
            if (IDX_W'(i) == idx_lo) begin
                tap_lo = tap_lo | raw_link[i].val;
            end
        end
    end

    assign median_next = {tap_lo[SAMPLE_W-1], tap_lo} + {tap_hi[SAMPLE_W-1], tap_hi};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= LEN_RESET;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            win_len_reg <= win_len_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && pend_reg) begin
            median_reg <= median_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_median_x2 = median_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(WINDOW_MAX))
        else $error("fill count exceeds the cell row");

    a_fill_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.clear |-> ($countones(vld_vec) == 32'(fill_reg)))
        else $error("valid cells disagree with the fill count");

    a_start_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_start_req) |=> (fill_reg == LEN_W'(1)))
        else $error("start transaction did not leave exactly one entry");

    a_pend_full: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (fill_reg == len_eff))
        else $error("median pending while the window is not full");

endmodule

// ===== rtl/core/swm_cell.sv =====
module swm_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  swm_pkg::cell_ctl_t ctl,
    input  swm_pkg::cell_fwd_t left_in,
    input  swm_pkg::cell_raw_t right_in,
    output swm_pkg::cell_raw_t raw_out,
    output swm_pkg::cell_fwd_t fwd_out
);
    import swm_pkg::*;

    logic             vld_reg;
    logic             vld_next;
    sample_t          val_reg;
    sample_t          val_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;

    logic             vld_e;
    logic             le_own;
    logic             del_own;
    logic             dle;
    logic             b_vld;
    sample_t          b_val;
    logic [AGE_W-1:0] b_age;
    logic             ble;

    // A start transaction makes every stored entry invisible for this cycle.
    assign vld_e   = vld_reg & ~ctl.clear;
    assign le_own  = vld_e && (val_reg <= ctl.sample);
    assign del_own = ctl.del && vld_e && (age_reg == ctl.del_age);

    // After the removal, this position holds the right neighbor's entry if
    // the removed one sat here or further left.
    assign dle   = left_in.dle | del_own;
    assign b_vld = dle ? right_in.vld : vld_e;
    assign b_val = dle ? right_in.val : val_reg;
    assign b_age = dle ? right_in.age : age_reg;
    assign ble   = dle ? right_in.le  : le_own;

    assign raw_out = '{vld: vld_e, val: val_reg, age: age_reg, le: le_own};
    assign fwd_out = '{dle: dle, ble: ble, vld: b_vld, val: b_val, age: b_age};

    always_comb begin
        if (!ctl.ins) begin
            vld_next = b_vld;
            val_next = b_val;
            age_next = b_age;
        end else if (ble) begin
            vld_next = 1'b1;
            val_next = b_val;
            age_next = b_age + AGE_W'(1);
        end else if (left_in.ble) begin
            vld_next = 1'b1;
            val_next = ctl.sample;
            age_next = '0;
        end else begin
            vld_next = left_in.vld;
            val_next = left_in.val;
            age_next = left_in.age + AGE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ctl.ins || ctl.del) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ins || ctl.del) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

// ===== bench/median_stream_check.sv =====
module median_stream_check (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [swm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]      pwdata,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  swm_pkg::sample_t                    s_sample,
    input  logic                                s_start_req,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [swm_pkg::OUT_W-1:0]    m_median_x2,

    output int                                  mismatch_count,
    output int                                  due_count,
    output int                                  medians_checked
);
    import swm_pkg::*;

    typedef logic signed [OUT_W-1:0] median_t;

    localparam logic [APB_ADDR_W-1:0] LEN_ADDR = {REG_WINDOW_LEN, 2'b00};

    // Window kept in ascending order; each entry carries its age, 0 being the newest.
    sample_t    win_val [WINDOW_MAX];
    int         win_age [WINDOW_MAX];
    int         win_fill;
    logic [5:0] len_reg;
    median_t    medians_due [$];

    int         n_mismatch;
    int         n_checked;
    median_t    want_med;
    median_t    new_med;

    function automatic int active_len();
        int len;
        len = int'(len_reg);
        if (len < 1) len = 1;
        if (len > WINDOW_MAX) len = WINDOW_MAX;
        return len;
    endfunction

    function automatic void drop_oldest_entry();
        int pos;
        int i;
        pos = 0;
        for (i = 1; i < win_fill; i++) begin
            if (win_age[i] >= win_age[pos]) pos = i;
        end
        for (i = pos; i + 1 < win_fill; i++) begin
            win_val[i] = win_val[i+1];
            win_age[i] = win_age[i+1];
        end
        win_fill--;
    endfunction

    // Takes one sample into the window; returns 1 when the window is full and a median is due.
    function automatic bit slide_window(input sample_t v, input logic clr, output median_t med);
        int len;
        int pos;
        int i;
        len = active_len();
        med = '0;
        if (clr) win_fill = 0;
        // A window made shorter since the last sample loses its oldest entries here.
        while (win_fill >= len) drop_oldest_entry();
        for (i = 0; i < win_fill; i++) win_age[i]++;
        pos = 0;
        while (pos < win_fill && win_val[pos] <= v) pos++;
        for (i = win_fill; i > pos; i--) begin
            win_val[i] = win_val[i-1];
            win_age[i] = win_age[i-1];
        end
        win_val[pos] = v;
        win_age[pos] = 0;
        win_fill++;
        if (win_fill != len) return 1'b0;
        if (len % 2 == 1)
            med = OUT_W'(win_val[len/2]) + OUT_W'(win_val[len/2]);
        else
            med = OUT_W'(win_val[len/2-1]) + OUT_W'(win_val[len/2]);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_fill   = 0;
            len_reg    = LEN_RESET[5:0];
            n_mismatch = 0;
            n_checked  = 0;
            medians_due.delete();
        end else begin
            // A result always trails its sample, so it is retired before a new sample is taken.
            if (m_valid && m_ready) begin
                if (medians_due.size() == 0) begin
                    $error("median_x2 transaction with none outstanding: expected none, got %0d",
                           m_median_x2);
                    n_mismatch++;
                end else begin
                    want_med = medians_due.pop_front();
                    n_checked++;
                    if (m_median_x2 !== want_med) begin
                        $error("median_x2 mismatch: expected %0d, got %0d", want_med, m_median_x2);
                        n_mismatch++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (slide_window(s_sample, s_start_req, new_med)) medians_due.push_back(new_med);
            end
            if (psel && penable && pwrite && pready && paddr == LEN_ADDR) len_reg = pwdata[5:0];
        end
        mismatch_count  <= n_mismatch;
        medians_checked <= n_checked;
        due_count       <= medians_due.size();
    end

endmodule

// ===== bench/sliding_window_median_tb.sv =====
module sliding_window_median_tb;
    import swm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 125;
    localparam logic [APB_ADDR_W-1:0] LEN_ADDR = {REG_WINDOW_LEN, 2'b00};
    localparam sample_t S_MAX = 32'sh7FFF_FFFF;
    localparam sample_t S_MIN = 32'sh8000_0000;

    logic                     aclk;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0]    pwdata;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     s_valid;
    logic                     s_ready;
    sample_t                  s_sample;
    logic                     s_start_req;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [OUT_W-1:0]  m_median_x2;

    int   mismatch_count;
    int   due_count;
    int   medians_checked;

    bit   steady;
    int   cycles;
    int   hold_left;
    int   samples_sent;
    int   settings_used;
    int   ph;
    int   k;
    int   eff;
    logic [5:0] len;

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sliding_window_median u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_start_req (s_start_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_median_x2 (m_median_x2)
    );

    median_stream_check u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_start_req     (s_start_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median_x2     (m_median_x2),
        .mismatch_count  (mismatch_count),
        .due_count       (due_count),
        .medians_checked (medians_checked)
    );

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small values give many ties; full-range values exercise every bit.
    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 4))
                0: return S_MIN;
                1: return S_MAX;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        if (r < 4) return sample_t'($urandom_range(0, 8)) - 4;
        return sample_t'($urandom());
    endfunction

    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            hold_left = pick_gap();
            m_ready <= (hold_left == 0);
            if (hold_left > 0) hold_left = hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d medians outstanding", cycles, due_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input sample_t smp, input logic st);
        int gap;
        bit took;
        gap = steady ? 0 : pick_gap();
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample    <= smp;
        s_start_req <= st;
        // s_ready is settled by the falling edge and holds until the next rising edge.
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        samples_sent++;
    endtask

    // Stops the sample stream until every outstanding median has come back.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_window_len(input logic [5:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEN_ADDR;
        pwdata  <= {26'($urandom()), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    initial begin
        s_valid     <= 1'b0;
        s_sample    <= '0;
        s_start_req <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        m_ready     <= 1'b0;
        aresetn     <= 1'b0;
        steady       = 1'b0;
        cycles       = 0;
        hold_left    = 0;
        samples_sent = 0;
        settings_used = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default window of three: extremes, then ties at the top of the range.
        send_item(S_MAX, 1'b1);
        send_item(S_MIN, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(S_MAX, 1'b0);

        // Shorter even window mid-stream; the sums reach both ends of the result range.
        settle();
        write_window_len(6'd2);
        send_item(S_MAX, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(S_MAX, 1'b1);
        send_item(S_MAX, 1'b0);

        // A length of zero behaves as a window of one.
        settle();
        write_window_len(6'd0);
        send_item(-1, 1'b0);
        send_item(1, 1'b1);
        send_item(S_MIN, 1'b0);

        // Longer window mid-stream has to refill before it reports again.
        settle();
        write_window_len(6'd5);
        send_item(7, 1'b0);
        send_item(7, 1'b0);
        send_item(-7, 1'b0);
        send_item(7, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(S_MIN, 1'b0);

        settle();
        write_window_len(6'd4);
        send_item(3, 1'b0);
        send_item(3, 1'b0);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: len = 6'd63;
                1: len = 6'd33;
                2: len = 6'd32;
                3: len = 6'd1;
                4: len = 6'd0;
                5: len = 6'd2;
                default: len = 6'($urandom_range(0, 63));
            endcase
            write_window_len(len);
            eff = (len == 0) ? 1 : ((len > WINDOW_MAX) ? WINDOW_MAX : int'(len));
            steady = (ph % 5 == 2);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_item(pick_sample(),
                          (k == 0 && $urandom_range(0, 1) == 1) ||
                          $urandom_range(0, 3 * eff + 8) == 0);
            end
            steady = 1'b0;
        end

        settle();
        repeat (40) @(posedge aclk);
        $display("Covered %0d samples under %0d window_len writes, extremes and length changes.",
                 samples_sent, settings_used);
        $display("%0d medians were compared with their predicted values.", medians_checked);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
